/* rtl/lae_pkg.sv */
// Shared types, operation codes and rule constants of the life automaton engine.
package lae_pkg;

    // Operation codes carried by the mode field
    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_KILL   = 3'd1;
    localparam logic [2:0] MODE_REVIVE = 3'd2;
    localparam logic [2:0] MODE_TOGGLE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;
    localparam logic [2:0] MODE_STEP   = 3'd5;

    // Neighbour count, 0..8
    typedef logic [3:0] cnt_t;

    // B3/S23 rule
    localparam cnt_t RULE_BIRTH = 4'd3;
    localparam cnt_t RULE_STAY  = 4'd2;

    function automatic logic rule_fate(input logic alive, input cnt_t n);
        if (alive)
        begin
            return (n == RULE_STAY) || (n == RULE_BIRTH);
        end
        return n == RULE_BIRTH;
    endfunction

endpackage

/* rtl/life_automaton_engine.sv */
// Top level of the life automaton engine: board memory, sequencer and result path.
//
// Usage: drive mode, cell_row and cell_col with start high; the command transfers
// at a rising edge where start is high and busy is low. busy stays high while the
// command runs. Exactly one result follows each command: cell_alive,
// live_neighbours and op_done stand on the ports for the single cycle in which
// result_strobe is high, and the receiver takes it at the end of that cycle; it
// cannot stall the block. The board is one row-wide memory with one read port
// and one write port, one row word per cycle.
// Steps of each command, from the transfer to the strobe:
//   read, clear, unused modes: three row reads for the report.
//   kill, revive, toggle:      read-modify-write of the row, then report.
//   next generation:           one row written per cycle, then report.
// One command is in flight at a time; a new one may transfer in the strobe cycle.
// Reset: all cells dead through per-row valid bits, so no clearing pass is needed;
// a clear command drops all valid bits together.
module life_automaton_engine
    import lae_pkg::*;
#(
    parameter int BOARD_SIZE = 64
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [2:0] mode,
    input  logic [5:0] cell_row,
    input  logic [5:0] cell_col,
    output logic       result_strobe,
    output logic       cell_alive,
    output cnt_t       live_neighbours,
    output logic       op_done
);

    localparam int RW = $clog2(BOARD_SIZE);
    localparam int IW = ((RW > 6) ? RW : 6) + 2;
    localparam logic [IW-1:0] SIZE_X = IW'(BOARD_SIZE);
    localparam logic [IW-1:0] LAST_X = IW'(BOARD_SIZE - 1);

    // Sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_C_RD  = 4'd1;
    localparam logic [3:0] ST_C_MOD = 4'd2;
    localparam logic [3:0] ST_G_ST  = 4'd3;
    localparam logic [3:0] ST_G_LD  = 4'd4;
    localparam logic [3:0] ST_G_ROW = 4'd5;
    localparam logic [3:0] ST_REP0  = 4'd6;
    localparam logic [3:0] ST_REP1  = 4'd7;
    localparam logic [3:0] ST_REP2  = 4'd8;
    localparam logic [3:0] ST_REP3  = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [2:0]            mode_reg, mode_next;
    logic [5:0]            row_reg, row_next;
    logic [5:0]            col_reg, col_next;
    logic [RW-1:0]         step_row_reg, step_row_next;
    logic [BOARD_SIZE-1:0] row_valid_reg, row_valid_next;
    logic [BOARD_SIZE-1:0] above_row_reg, above_row_next;
    logic [BOARD_SIZE-1:0] here_row_reg, here_row_next;
    logic                  strobe_reg, strobe_next;
    logic                  alive_reg, alive_next;
    cnt_t                  nbr_reg, nbr_next;
    logic                  done_reg, done_next;

    // Board memory and its read/write ports
    logic [BOARD_SIZE-1:0] board_mem [BOARD_SIZE];
    logic [BOARD_SIZE-1:0] rd_data_reg;
    logic                  rd_valid_reg;
    logic [RW-1:0]         rd_addr;
    logic                  wr_en;
    logic [RW-1:0]         wr_addr;
    logic [BOARD_SIZE-1:0] wr_data;
    logic [BOARD_SIZE-1:0] rd_row;

    // Address arithmetic in a width wide enough to see the board edges
    logic [IW-1:0]         r_x, c_x, up_x, dn_x, step_x, step_nx, step_nnx;
    logic                  up_ok, mid_ok, dn_ok, in_board;
    logic [BOARD_SIZE-1:0] mod_row;
    logic [BOARD_SIZE-1:0] rule_above, rule_below, rule_fresh;
    logic [BOARD_SIZE-1:0] dn_row;

    // Cell of a row at a position; positions off the board read dead
    function automatic logic pick(input logic [BOARD_SIZE-1:0] row, input logic [IW-1:0] idx);
        if (idx < SIZE_X)
        begin
            return row[idx[RW-1:0]];
        end
        return 1'b0;
    endfunction

    assign r_x      = IW'(row_reg);
    assign c_x      = IW'(col_reg);
    assign up_x     = r_x - IW'(1);
    assign dn_x     = r_x + IW'(1);
    assign up_ok    = up_x < SIZE_X;
    assign mid_ok   = r_x < SIZE_X;
    assign dn_ok    = dn_x < SIZE_X;
    assign in_board = mid_ok && (c_x < SIZE_X);
    assign step_x   = IW'(step_row_reg);
    assign step_nx  = step_x + IW'(1);
    assign step_nnx = step_x + IW'(2);

    // Rows never written since reset or clear read as all dead
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

    always_ff @(posedge clk)
    begin
        rd_data_reg <= board_mem[rd_addr];
        if (wr_en)
        begin
            board_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    // Single-cell modification of the fetched row
    always_comb
    begin
        mod_row = rd_row;
        if (in_board)
        begin
            unique case (mode_reg)
                MODE_KILL:   mod_row[c_x[RW-1:0]] = 1'b0;
                MODE_REVIVE: mod_row[c_x[RW-1:0]] = 1'b1;
                MODE_TOGGLE: mod_row[c_x[RW-1:0]] = ~rd_row[c_x[RW-1:0]];
                default:     mod_row = rd_row;
            endcase
        end
    end

    // Generation window: row zero has no row above, the last row none below
    assign rule_above = (step_row_reg == '0) ? '0 : above_row_reg;
    assign rule_below = (step_nx < SIZE_X) ? rd_row : '0;

    lae_row_rule #(
        .BOARD_SIZE (BOARD_SIZE)
    ) u_rule (
        .above (rule_above),
        .here  (here_row_reg),
        .below (rule_below),
        .fresh (rule_fresh)
    );

    assign dn_row = dn_ok ? rd_row : '0;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        step_row_next  = step_row_reg;
        row_valid_next = row_valid_reg;
        above_row_next = above_row_reg;
        here_row_next  = here_row_reg;
        strobe_next    = 1'b0;
        alive_next     = alive_reg;
        nbr_next       = nbr_reg;
        done_next      = done_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = step_row_reg;
        wr_data        = rule_fresh;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    mode_next = mode;
                    row_next  = cell_row;
                    col_next  = cell_col;
                    unique case (mode) inside
                        MODE_CLEAR:
                        begin
                            row_valid_next = '0;
                            state_next     = ST_REP0;
                        end
                        MODE_STEP:
                            state_next = ST_G_ST;
                        MODE_KILL, MODE_REVIVE, MODE_TOGGLE:
                            state_next = ST_C_RD;
                        default:
                            state_next = ST_REP0;
                    endcase
                end
            end
            ST_C_RD:
            begin
                rd_addr    = r_x[RW-1:0];
                state_next = ST_C_MOD;
            end
            ST_C_MOD:
            begin
                wr_en   = in_board;
                wr_addr = r_x[RW-1:0];
                wr_data = mod_row;
                if (in_board)
                begin
                    row_valid_next[r_x[RW-1:0]] = 1'b1;
                end
                state_next = ST_REP0;
            end
            ST_G_ST:
            begin
                rd_addr       = '0;
                step_row_next = '0;
                state_next    = ST_G_LD;
            end
            ST_G_LD:
            begin
                here_row_next = rd_row;
                rd_addr       = RW'(1);
                state_next    = ST_G_ROW;
            end
            ST_G_ROW:
            begin
                wr_en                        = 1'b1;
                wr_addr                      = step_row_reg;
                wr_data                      = rule_fresh;
                row_valid_next[step_row_reg] = 1'b1;
                above_row_next               = here_row_reg;
                here_row_next                = rule_below;
                rd_addr = (step_nnx < SIZE_X) ? step_nnx[RW-1:0] : '0;
                if (step_x == LAST_X)
                begin
                    step_row_next = '0;
                    state_next    = ST_REP0;
                end
                else
                begin
                    step_row_next = step_row_reg + RW'(1);
                end
            end
            ST_REP0:
            begin
                rd_addr    = up_x[RW-1:0];
                state_next = ST_REP1;
            end
            ST_REP1:
            begin
                above_row_next = up_ok ? rd_row : '0;
                rd_addr        = r_x[RW-1:0];
                state_next     = ST_REP2;
            end
            ST_REP2:
            begin
                here_row_next = mid_ok ? rd_row : '0;
                rd_addr       = dn_x[RW-1:0];
                state_next    = ST_REP3;
            end
            ST_REP3:
            begin
                alive_next  = pick(here_row_reg, c_x);
                nbr_next    = cnt_t'(pick(above_row_reg, c_x - IW'(1)))
                            + cnt_t'(pick(above_row_reg, c_x))
                            + cnt_t'(pick(above_row_reg, c_x + IW'(1)))
                            + cnt_t'(pick(here_row_reg, c_x - IW'(1)))
                            + cnt_t'(pick(here_row_reg, c_x + IW'(1)))
                            + cnt_t'(pick(dn_row, c_x - IW'(1)))
                            + cnt_t'(pick(dn_row, c_x))
                            + cnt_t'(pick(dn_row, c_x + IW'(1)));
                done_next   = 1'b1;
                strobe_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_row_reg  <= '0;
            row_valid_reg <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_row_reg  <= step_row_next;
            row_valid_reg <= row_valid_next;
            strobe_reg    <= strobe_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        above_row_reg <= above_row_next;
        here_row_reg  <= here_row_next;
        alive_reg     <= alive_next;
        nbr_reg       <= nbr_next;
        done_reg      <= done_next;
    end

    assign busy            = state_reg != ST_IDLE;
    assign result_strobe   = strobe_reg;
    assign cell_alive      = alive_reg;
    assign live_neighbours = nbr_reg;
    assign op_done         = done_reg;

    // Checks
    a_report_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REP3) |=> (result_strobe && !busy))
        else $error("result strobe missing after report");

    a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(state_reg == ST_REP3))
        else $error("result strobe without a report");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_step_row_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (step_row_reg == '0))
        else $error("generation row counter not back at zero");

endmodule

/* rtl/lae_row_rule.sv */
// One-row generation update: new row from the old rows above, at and below.
module lae_row_rule
    import lae_pkg::*;
#(
    parameter int BOARD_SIZE = 64
)
(
    input  logic [BOARD_SIZE-1:0] above,
    input  logic [BOARD_SIZE-1:0] here,
    input  logic [BOARD_SIZE-1:0] below,
    output logic [BOARD_SIZE-1:0] fresh
);

    // Rows padded with a dead cell on each side so edges count as dead
    logic [BOARD_SIZE+1:0] above_pad;
    logic [BOARD_SIZE+1:0] here_pad;
    logic [BOARD_SIZE+1:0] below_pad;

    assign above_pad = {1'b0, above, 1'b0};
    assign here_pad  = {1'b0, here, 1'b0};
    assign below_pad = {1'b0, below, 1'b0};

    // Independent per-column neighbour count and rule
    always_comb
    begin
        for (int j = 0; j < BOARD_SIZE; j++)
        begin
            cnt_t n;
            n = cnt_t'(above_pad[j]) + cnt_t'(above_pad[j+1]) + cnt_t'(above_pad[j+2])
              + cnt_t'(here_pad[j]) + cnt_t'(here_pad[j+2])
              + cnt_t'(below_pad[j]) + cnt_t'(below_pad[j+1]) + cnt_t'(below_pad[j+2]);
            fresh[j] = rule_fate(here[j], n);
        end
    end

endmodule
